>>> design/izn_pkg.sv
// Shared types, register indexes and fixed-point helpers for the neuron step.
// No dependencies; imported by izn_ctrl, izn_datapath and izhikevich_neuron_step.
package izn_pkg;

  // Register indexes on the configuration port
  localparam logic [3:0] REG_DT_OVER_CAP         = 4'd0;
  localparam logic [3:0] REG_RECOV_RATE_DT       = 4'd1;
  localparam logic [3:0] REG_RECOV_SENSITIVITY   = 4'd2;
  localparam logic [3:0] REG_RESET_POTENTIAL     = 4'd3;
  localparam logic [3:0] REG_RESET_INCREMENT     = 4'd4;
  localparam logic [3:0] REG_REST_POTENTIAL      = 4'd5;
  localparam logic [3:0] REG_THRESHOLD_POTENTIAL = 4'd6;
  localparam logic [3:0] REG_PEAK_POTENTIAL      = 4'd7;

  // Register reset values, Q16.16 but for the recovery rate, which is unsigned Q0.16
  localparam logic [31:0]        RST_DT_OVER_CAP         = 32'd4312;
  localparam logic [15:0]        RST_RECOV_RATE_DT       = 16'd655;
  localparam logic signed [31:0] RST_RECOV_SENSITIVITY   = -32'sd1310720;
  localparam logic signed [31:0] RST_RESET_POTENTIAL     = -32'sd3604480;
  localparam logic signed [31:0] RST_RESET_INCREMENT     = 32'sd5963776;
  localparam logic signed [31:0] RST_REST_POTENTIAL      = -32'sd5242880;
  localparam logic signed [31:0] RST_THRESHOLD_POTENTIAL = -32'sd1946419;
  localparam logic signed [31:0] RST_PEAK_POTENTIAL      = 32'sd2621440;

  // Recovery rate register is pure fraction
  localparam int RATE_BITS = 16;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  // Controller commands to the datapath, one phase per cycle; the finish phase waits while the output is stalled
  typedef struct packed {
    logic load;
    logic mul;
    logic post1;
    logic post2;
    logic diff;
    logic post3;
    logic post4;
    logic finish;
  } izn_cmd_t;

  // Clipped 32-bit value and its clip flag
  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] x);
    sat_t r;
    if (x > MAX32) begin
      r.clip = 1'b1;
      r.val  = 32'h7fff_ffff;
    end else if (x < MIN32) begin
      r.clip = 1'b1;
      r.val  = 32'h8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> design/izn_ctrl.sv
// Sequencer for one neuron step: walks the datapath through its phases.
// Depends on izn_pkg for the command struct.
module izn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output izn_pkg::izn_cmd_t  cmd
);
  import izn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_POST1 = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_POST2 = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_POST3 = 4'd7;
  localparam logic [3:0] S_MUL4  = 4'd8;
  localparam logic [3:0] S_POST4 = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_MUL1;
      S_MUL1:  state_next = S_POST1;
      S_POST1: state_next = S_MUL2;
      S_MUL2:  state_next = S_POST2;
      S_POST2: state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL3;
      S_MUL3:  state_next = S_POST3;
      S_POST3: state_next = S_MUL4;
      S_MUL4:  state_next = S_POST4;
      S_POST4: state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode phase commands
  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.mul    = (state == S_MUL1) || (state == S_MUL2) ||
                 (state == S_MUL3) || (state == S_MUL4);
    cmd.post1  = (state == S_POST1);
    cmd.post2  = (state == S_POST2);
    cmd.diff   = (state == S_DIFF);
    cmd.post3  = (state == S_POST3);
    cmd.post4  = (state == S_POST4);
    cmd.finish = (state == S_FIN) && out_free;
  end

  // Advance state; hold result valid until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/izn_datapath.sv
// Datapath for the neuron step: configuration registers, state, one shared
// multiplier with a product register, and the output register. Uses izn_pkg.
module izn_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  izn_pkg::izn_cmd_t  cmd,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] drive_current,
  output logic signed [31:0] membrane_out,
  output logic signed [31:0] recovery_out,
  output logic               spiked,
  output logic               saturated
);
  import izn_pkg::*;

  // Configuration
  logic [31:0]        dt_over_cap;
  logic [15:0]        recov_rate_dt;
  logic signed [31:0] recov_sensitivity;
  logic signed [31:0] reset_potential;
  logic signed [31:0] reset_increment;
  logic signed [31:0] rest_potential;
  logic signed [31:0] threshold_potential;
  logic signed [31:0] peak_potential;

  // Neuron state and working registers
  logic signed [31:0] membrane;
  logic signed [31:0] recovery;
  logic signed [31:0] drive;
  logic signed [31:0] vn;
  logic signed [31:0] un;
  logic               spk;
  logic               clip;
  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] prod;

  sat_t d1_s, d2_s, q_s, s_s, dv_s, vn_s, dr_s, bv_s, w_s, un_s, ud_s;
  logic signed [65:0] prod_f;
  logic signed [65:0] prod_r;

  assign prod_f = prod >>> FRAC_BITS;
  assign prod_r = prod >>> RATE_BITS;

  always_comb begin
    d1_s = sat32(66'(membrane) - 66'(rest_potential));
    d2_s = sat32(66'(membrane) - 66'(threshold_potential));
    q_s  = sat32(prod_f);
    s_s  = sat32(66'($signed(q_s.val)) - 66'(recovery) + 66'(drive));
    dv_s = sat32(prod_f);
    vn_s = sat32(66'(membrane) + 66'($signed(dv_s.val)));
    dr_s = sat32(66'(vn) - 66'(rest_potential));
    bv_s = sat32(prod_f);
    w_s  = sat32(66'($signed(bv_s.val)) - 66'(recovery));
    un_s = sat32(66'(recovery) + prod_r);
    ud_s = sat32(66'(un) + 66'(reset_increment));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dt_over_cap         <= RST_DT_OVER_CAP;
      recov_rate_dt       <= RST_RECOV_RATE_DT;
      recov_sensitivity   <= RST_RECOV_SENSITIVITY;
      reset_potential     <= RST_RESET_POTENTIAL;
      reset_increment     <= RST_RESET_INCREMENT;
      rest_potential      <= RST_REST_POTENTIAL;
      threshold_potential <= RST_THRESHOLD_POTENTIAL;
      peak_potential      <= RST_PEAK_POTENTIAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DT_OVER_CAP:         dt_over_cap         <= cfg_data;
        REG_RECOV_RATE_DT:       recov_rate_dt       <= cfg_data[15:0];
        REG_RECOV_SENSITIVITY:   recov_sensitivity   <= $signed(cfg_data);
        REG_RESET_POTENTIAL:     reset_potential     <= $signed(cfg_data);
        REG_RESET_INCREMENT:     reset_increment     <= $signed(cfg_data);
        REG_REST_POTENTIAL:      rest_potential      <= $signed(cfg_data);
        REG_THRESHOLD_POTENTIAL: threshold_potential <= $signed(cfg_data);
        REG_PEAK_POTENTIAL:      peak_potential      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Neuron state: update only when the result is handed to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      membrane <= RST_RESET_POTENTIAL;
      recovery <= '0;
    end else if (cmd.finish) begin
      if (spk) begin
        membrane <= reset_potential;
        recovery <= $signed(ud_s.val);
      end else begin
        membrane <= vn;
        recovery <= un;
      end
    end
  end

  // Phase sequence of the working registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= opa * opb;
    end
    if (cmd.load) begin
      // Potential offsets from rest and threshold
      drive <= drive_current;
      opa   <= 33'($signed(d1_s.val));
      opb   <= 33'($signed(d2_s.val));
      clip  <= d1_s.clip | d2_s.clip;
    end
    if (cmd.post1) begin
      // Quadratic term, net current, then scale by dt/C
      opa  <= $signed({1'b0, dt_over_cap});
      opb  <= 33'($signed(s_s.val));
      clip <= clip | q_s.clip | s_s.clip;
    end
    if (cmd.post2) begin
      vn   <= $signed(vn_s.val);
      clip <= clip | dv_s.clip | vn_s.clip;
    end
    if (cmd.diff) begin
      // New potential above rest, times sensitivity
      opa  <= 33'(recov_sensitivity);
      opb  <= 33'($signed(dr_s.val));
      spk  <= (vn > peak_potential);
      clip <= clip | dr_s.clip;
    end
    if (cmd.post3) begin
      opa  <= $signed({17'b0, recov_rate_dt});
      opb  <= 33'($signed(w_s.val));
      clip <= clip | bv_s.clip | w_s.clip;
    end
    if (cmd.post4) begin
      un   <= $signed(un_s.val);
      clip <= clip | un_s.clip;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      membrane_out <= spk ? reset_potential : vn;
      recovery_out <= spk ? $signed(ud_s.val) : un;
      spiked       <= spk;
      saturated    <= clip | (spk & ud_s.clip);
    end
  end

endmodule

>>> design/izhikevich_neuron_step.sv
// Top level of the neuron step: controller plus datapath.
// Depends on izn_pkg, izn_ctrl and izn_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  input    | in_valid / in_stall  | drive_current
//  output   | out_valid / out_stall| membrane_out, recovery_out, spiked, saturated
//  config   | cfg_we               | cfg_index, cfg_data
//
// One item runs through the four dependent products that share one multiplier
// (multiply, then post-process), the spike compare and the final load; a new
// item is not taken while the last one is still in any of its phases.
// The controller returns to idle as the result is loaded, so a new item can be taken in the next cycle.
// A stalled output holds the finished step in its last phase until the register frees.
// Reset is synchronous; it restores configuration registers, state and an empty output.
module izhikevich_neuron_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] drive_current,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] membrane_out,
  output logic signed [31:0] recovery_out,
  output logic               spiked,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import izn_pkg::*;

  izn_cmd_t cmd;

  izn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  izn_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .drive_current (drive_current),
    .membrane_out  (membrane_out),
    .recovery_out  (recovery_out),
    .spiked        (spiked),
    .saturated     (saturated)
  );

endmodule
